/* rtl/mso_pkg.sv */
package mso_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_W = 32;
	localparam int MULT_W = 6;
	localparam int ROOT_IN_W = 64;
	localparam int ROOT_W = 32;
	localparam int COUNT_OUT_W = 11;
	localparam logic [MULT_W-1:0] SIGMA_MULT_RESET = 6'd3;

	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_SEL   = 9'b000000010,
		ST_SQ    = 9'b000000100,
		ST_DIVS  = 9'b000001000,
		ST_SQRT  = 9'b000010000,
		ST_SPLIT = 9'b000100000,
		ST_DIVC  = 9'b001000000,
		ST_DIVO  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

endpackage

/* rtl/mso_mem.sv */
module mso_mem
	import mso_pkg::*;
#(
	parameter int DEPTH = MAX_SAMPLES_DEF,
	parameter int AW = $clog2(MAX_SAMPLES_DEF)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mso_div.sv */
module mso_div #(
	parameter int DW = 75,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   dvd_q;
	logic [VW-1:0]   dsr_q;
	logic [VW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW-1:0]   quo_q;
	logic [VW:0]     rem2;
	logic            ge;

	assign rem2 = {rem_q, dvd_q[DW-1]};
	assign ge = rem2 >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (ge) begin
				rem_q <= VW'(rem2 - {1'b0, dsr_q});
			end else begin
				rem_q <= rem2[VW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/mso_isqrt.sv */
module mso_isqrt
	import mso_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ROOT_IN_W-1:0] value,
	output logic                 done,
	output logic [ROOT_W-1:0]    root
);

	logic [ROOT_IN_W-1:0] v_q;
	logic [ROOT_IN_W-1:0] res_q;
	logic [ROOT_IN_W-1:0] one_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ROOT_IN_W-1:0] trial;

	assign trial = res_q + one_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && one_q == ROOT_IN_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			res_q <= '0;
			one_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

/* rtl/median_sigma_outlier_split_unit.sv */
// Samples load at one transaction per cycle while the unit is in its load state.
// After the last sample: 32 median bit passes, a squared deviation pass, a split pass,
// three serial divisions, a root and a load of the result, which waits for the output to
// be free; a one-sample set skips the first division and the root. The result register
// frees the input once loaded, so a new set is taken only after the last result is loaded.
// Reset clears control, the count and the multiple (to 3); the store is not cleared.
module median_sigma_outlier_split_unit
	import mso_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [MULT_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_W-1:0]    median,
	output logic [SAMPLE_W-1:0]    clean_mean,
	output logic [SAMPLE_W-1:0]    outlier_mean,
	output logic [COUNT_OUT_W-1:0] outlier_count,
	output logic                   clean_empty
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SQW = 2 * SAMPLE_W;
	localparam int DW = SQW + CW;
	localparam int SUMW = SAMPLE_W + CW;
	localparam int THRW = SAMPLE_W + MULT_W + 2;

	state_t state_q;
	logic [MULT_W-1:0] mult_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic rdv_s1;
	logic v_s2;
	logic [SAMPLE_W-1:0] d_s2;
	logic v_s3;
	logic [SQW-1:0] sq_s3;
	logic [4:0] bit_q;
	logic [SAMPLE_W-1:0] prefix_q;
	logic [CW-1:0] rank_q;
	logic [CW-1:0] selc_q;
	logic [SAMPLE_W-1:0] med_q;
	logic [DW-1:0] acc_q;
	logic [THRW-1:0] thr_q;
	logic [CW-1:0] ncl_q;
	logic [CW-1:0] nout_q;
	logic [SUMW-1:0] scl_q;
	logic [SUMW-1:0] sout_q;
	logic [SAMPLE_W-1:0] cmean_q;
	logic [SAMPLE_W-1:0] omean_q;
	logic ovalid_q;
	logic div_start_q;
	logic sqrt_start_q;

	logic in_acc;
	logic full;
	logic [CW-1:0] cnt_next;
	logic pass_st;
	logic rd_en;
	logic [SAMPLE_W-1:0] rd_data;
	logic pass_end;
	logic [SAMPLE_W-1:0] hmask;
	logic sel_hit;
	logic [CW-1:0] nhalf;
	logic [DW-1:0] div_dvd;
	logic [CW-1:0] div_dsr;
	logic div_done;
	logic [DW-1:0] div_quo;
	logic sqrt_done;
	logic [ROOT_W-1:0] root;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_ready = state_q == ST_LOAD;
	assign in_acc = in_valid && in_ready;
	assign full = cnt_q == CW'(MAX_SAMPLES);
	assign cnt_next = full ? cnt_q : cnt_q + 1'b1;
	assign pass_st = state_q == ST_SEL || state_q == ST_SQ || state_q == ST_SPLIT;
	assign rd_en = pass_st && idx_q < n_q;
	assign pass_end = pass_st && idx_q == n_q && !rdv_s1 && !v_s2 && !v_s3;
	assign hmask = 32'hFFFF_FFFE << bit_q;
	assign sel_hit = ((rd_data ^ prefix_q) & hmask) == '0 && !rd_data[bit_q];
	assign nhalf = n_q >> 1;
	assign out_free = !ovalid_q || out_ready;

	mso_mem #(.DEPTH(MAX_SAMPLES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (in_acc && !full),
		.waddr (cnt_q[AW-1:0]),
		.wdata (sample),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		div_dvd = acc_q;
		div_dsr = nhalf;
		case (state_q)
			ST_DIVC: begin
				div_dvd = DW'(scl_q);
				div_dsr = ncl_q;
			end
			ST_DIVO: begin
				div_dvd = DW'(sout_q);
				div_dsr = nout_q;
			end
			default: begin
				div_dvd = acc_q;
				div_dsr = nhalf;
			end
		endcase
	end

	mso_div #(.DW(DW), .VW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	mso_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start_q),
		.value  (div_quo[ROOT_IN_W-1:0]),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			mult_q <= SIGMA_MULT_RESET;
			cnt_q <= '0;
			idx_q <= '0;
			rdv_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ovalid_q <= 1'b0;
			div_start_q <= 1'b0;
			sqrt_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			sqrt_start_q <= 1'b0;
			if (cfg_valid) begin
				mult_q <= cfg_data;
			end
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			rdv_s1 <= rd_en;
			v_s2 <= rdv_s1 && state_q == ST_SQ;
			v_s3 <= v_s2;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (last) begin
							cnt_q <= '0;
							idx_q <= '0;
							state_q <= ST_SEL;
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				ST_SEL: begin
					if (pass_end) begin
						idx_q <= '0;
						if (bit_q == 5'd0) begin
							state_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					if (pass_end) begin
						idx_q <= '0;
						if (nhalf == '0) begin
							state_q <= ST_SPLIT;
						end else begin
							div_start_q <= 1'b1;
							state_q <= ST_DIVS;
						end
					end
				end
				ST_DIVS: begin
					if (div_done) begin
						sqrt_start_q <= 1'b1;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (pass_end) begin
						div_start_q <= 1'b1;
						state_q <= ST_DIVC;
					end
				end
				ST_DIVC: begin
					if (div_done) begin
						div_start_q <= 1'b1;
						state_q <= ST_DIVO;
					end
				end
				ST_DIVO: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		d_s2 <= (rd_data < med_q) ? med_q - rd_data : '0;
		sq_s3 <= d_s2 * d_s2;
		case (state_q)
			ST_LOAD: begin
				n_q <= cnt_next;
				bit_q <= 5'd31;
				prefix_q <= '0;
				rank_q <= (cnt_next - 1'b1) >> 1;
				selc_q <= '0;
				acc_q <= '0;
			end
			ST_SEL: begin
				if (rdv_s1 && sel_hit) begin
					selc_q <= selc_q + 1'b1;
				end
				if (pass_end) begin
					selc_q <= '0;
					bit_q <= bit_q - 1'b1;
					if (rank_q >= selc_q) begin
						prefix_q[bit_q] <= 1'b1;
						rank_q <= rank_q - selc_q;
						med_q <= prefix_q | (SAMPLE_W'(1) << bit_q);
					end else begin
						med_q <= prefix_q;
					end
				end
			end
			ST_SQ: begin
				if (v_s3) begin
					acc_q <= acc_q + DW'(sq_s3);
				end
				thr_q <= THRW'(med_q);
				ncl_q <= '0;
				nout_q <= '0;
				scl_q <= '0;
				sout_q <= '0;
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					thr_q <= THRW'(med_q) + THRW'(mult_q) * THRW'(root);
				end
			end
			ST_SPLIT: begin
				if (rdv_s1) begin
					if (THRW'(rd_data) < thr_q) begin
						ncl_q <= ncl_q + 1'b1;
						scl_q <= scl_q + SUMW'(rd_data);
					end else begin
						nout_q <= nout_q + 1'b1;
						sout_q <= sout_q + SUMW'(rd_data);
					end
				end
			end
			ST_DIVC: begin
				if (div_done) begin
					cmean_q <= (ncl_q == '0) ? '0 : div_quo[SAMPLE_W-1:0];
				end
			end
			ST_DIVO: begin
				if (div_done) begin
					omean_q <= (nout_q == '0) ? '0 : div_quo[SAMPLE_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					median <= med_q;
					clean_mean <= cmean_q;
					outlier_mean <= omean_q;
					outlier_count <= COUNT_OUT_W'(nout_q);
					clean_empty <= ncl_q == '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = ovalid_q;

endmodule

/* sim/median_sigma_outlier_split_unit_tb.sv */
module median_sigma_outlier_split_unit_tb;
	import mso_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PART_ITEMS = 34;

	typedef struct {
		logic [SAMPLE_W-1:0]    median;
		logic [SAMPLE_W-1:0]    clean_mean;
		logic [SAMPLE_W-1:0]    outlier_mean;
		logic [COUNT_OUT_W-1:0] outlier_count;
		logic                   clean_empty;
	} split_result_t;

	class split_scoreboard;
		bit [SAMPLE_W-1:0] stored[STORE_DEPTH];
		int unsigned       stored_count;
		bit [MULT_W-1:0]   multiple;
		split_result_t     awaited[$];
		int                mismatches;

		function new();
			stored_count = 0;
			multiple = SIGMA_MULT_RESET;
			mismatches = 0;
		endfunction

		function bit [63:0] floor_root(bit [63:0] v);
			bit [63:0] res;
			bit [63:0] one;
			res = 0;
			one = 64'd1 << 62;
			while (one > v)
				one = one >> 2;
			while (one != 0) begin
				if (v >= res + one) begin
					v = v - (res + one);
					res = (res >> 1) + one;
				end else begin
					res = res >> 1;
				end
				one = one >> 2;
			end
			return res;
		endfunction

		function void note_sample(bit [SAMPLE_W-1:0] s, bit l);
			bit [SAMPLE_W-1:0] sorted[STORE_DEPTH];
			bit [SAMPLE_W-1:0] v;
			bit [SAMPLE_W-1:0] med;
			bit [127:0]        sq_sum;
			bit [127:0]        sq_mean;
			bit [63:0]         d;
			bit [63:0]         sigma;
			bit [63:0]         thr;
			bit [63:0]         clean_sum;
			bit [63:0]         out_sum;
			int unsigned       n, i, j, half, n_clean, n_out;
			split_result_t     r;
			if (stored_count < STORE_DEPTH) begin
				stored[stored_count] = s;
				stored_count++;
			end
			if (!l)
				return;
			n = stored_count;
			stored_count = 0;
			for (i = 0; i < n; i++) begin
				v = stored[i];
				j = i;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
			end
			med = sorted[(n-1)/2];
			half = n / 2;
			sigma = 0;
			if (half > 0) begin
				sq_sum = 0;
				for (i = 0; i < half; i++) begin
					d = {32'd0, med - sorted[i]};
					sq_sum = sq_sum + {64'd0, d * d};
				end
				sq_mean = sq_sum / half;
				sigma = floor_root(sq_mean[63:0]);
			end
			thr = {32'd0, med} + {58'd0, multiple} * sigma;
			clean_sum = 0;
			out_sum = 0;
			n_clean = 0;
			n_out = 0;
			for (i = 0; i < n; i++) begin
				if ({32'd0, stored[i]} < thr) begin
					n_clean++;
					clean_sum += stored[i];
				end else begin
					n_out++;
					out_sum += stored[i];
				end
			end
			r.median = med;
			r.clean_mean = n_clean ? SAMPLE_W'(clean_sum / n_clean) : '0;
			r.outlier_mean = n_out ? SAMPLE_W'(out_sum / n_out) : '0;
			r.outlier_count = COUNT_OUT_W'(n_out);
			r.clean_empty = (n_clean == 0);
			awaited.push_back(r);
		endfunction

		function void report(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, actual %h", what, want, got);
		endfunction

		function void check_result(split_result_t got);
			split_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction, median %h", got.median);
				return;
			end
			want = awaited.pop_front();
			if (got.median !== want.median)
				report("median", want.median, got.median);
			if (got.clean_mean !== want.clean_mean)
				report("clean_mean", want.clean_mean, got.clean_mean);
			if (got.outlier_mean !== want.outlier_mean)
				report("outlier_mean", want.outlier_mean, got.outlier_mean);
			if (got.outlier_count !== want.outlier_count)
				report("outlier_count", want.outlier_count, got.outlier_count);
			if (got.clean_empty !== want.clean_empty)
				report("clean_empty", want.clean_empty, got.clean_empty);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [MULT_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [SAMPLE_W-1:0]    sample;
	logic                   last;
	logic                   out_valid;
	logic                   out_ready;
	logic [SAMPLE_W-1:0]    median;
	logic [SAMPLE_W-1:0]    clean_mean;
	logic [SAMPLE_W-1:0]    outlier_mean;
	logic [COUNT_OUT_W-1:0] outlier_count;
	logic                   clean_empty;

	split_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	int unsigned     cycles;
	bit              out_seen;
	split_result_t   out_capture;

	median_sigma_outlier_split_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .median(median),
		.clean_mean(clean_mean), .outlier_mean(outlier_mean),
		.outlier_count(outlier_count), .clean_empty(clean_empty)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Output fields are captured at the falling edge, where they are stable.
	always @(negedge clk) begin
		out_seen = out_valid && out_ready;
		out_capture.median = median;
		out_capture.clean_mean = clean_mean;
		out_capture.outlier_mean = outlier_mean;
		out_capture.outlier_count = outlier_count;
		out_capture.clean_empty = clean_empty;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_seen)
				sb.check_result(out_capture);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_multiple(bit [MULT_W-1:0] v);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		sb.multiple = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(bit [SAMPLE_W-1:0] s, bit l);
		bit rdy;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample <= s;
		last <= l;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		sb.note_sample(s, l);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_set(input int unsigned budget, output int unsigned sent);
		int unsigned n, i, pick, style;
		bit [SAMPLE_W-1:0] base, s;
		pick = $urandom_range(99);
		if (pick < 80)
			n = $urandom_range(12, 1);
		else if (pick < 95)
			n = $urandom_range(64, 13);
		else
			n = $urandom_range(200, 65);
		if (n > budget)
			n = budget;
		style = $urandom_range(3);
		base = $urandom;
		for (i = 0; i < n; i++) begin
			case (style)
				0: s = $urandom;
				1: s = base + $urandom_range(255);
				2: s = ($urandom_range(9) == 0) ? base + $urandom : base;
				default: s = {16'd0, 16'($urandom)} << $urandom_range(16);
			endcase
			send_sample(s, i == n - 1);
		end
		sent = n;
	endtask

	initial begin
		int unsigned phase, part, total, sent, i;
		sb = new();
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		in_valid = 0;
		sample = '0;
		last = 0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_multiple(6'd0);
		send_sample(32'h0000_0000, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b1);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'h0002_0000, 1'b0);
		send_sample(32'h0003_0000, 1'b1);
		drain();
		write_multiple(6'd63);
		for (i = 0; i < 5; i++)
			send_sample(32'h1234_5678, i == 4);
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'h0000_0002, 1'b0);
		send_sample(32'h0000_0003, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		drain();
		write_multiple(SIGMA_MULT_RESET);
		for (i = 0; i < STORE_DEPTH + 6; i++)
			send_sample($urandom_range(65535) + ((i % 97 == 0) ? 32'h8000_0000 : 0),
				i == STORE_DEPTH + 5);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
			recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 33 : 0;
			for (part = 0; part < 2; part++) begin
				drain();
				if (part == 1)
					write_multiple(MULT_W'($urandom));
				else
					write_multiple((phase == 0) ? 6'd63 : (phase == 1) ? 6'd0 : 6'd3);
				total = 0;
				while (total < PART_ITEMS) begin
					send_random_set(PART_ITEMS - total, sent);
					total += sent;
				end
			end
		end
		drain();

		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/mso_pkg.sv
rtl/mso_mem.sv
rtl/mso_div.sv
rtl/mso_isqrt.sv
rtl/median_sigma_outlier_split_unit.sv
sim/median_sigma_outlier_split_unit_tb.sv
